### rtl/core/pgtr_pkg.sv
// Package for the periodic grid trilinear readout block.
// Holds shared constants, the operation code, the back-end state enum and
// a floor log2 helper function. No dependencies.
package pgtr_pkg;

    localparam int DEF_GRID_SIDE  = 32;
    localparam int DEF_VALUE_BITS = 24;
    localparam int DEF_POS_BITS   = 24;

    localparam int SCALE_BITS = 24;
    localparam int IDX_BITS   = 15;
    localparam int CVAL_BITS  = 24;
    localparam int OUT_BITS   = 24;
    localparam int MAX_BITS   = 23;
    localparam int FRAC_BITS  = 17;   // fraction 0..65536
    localparam logic [SCALE_BITS-1:0] SCALE_RESET = 24'd65536;
    localparam logic [FRAC_BITS-1:0]  FRAC_ONE    = 17'd65536;

    typedef enum logic
    {
        OP_WRITE  = 1'b0,
        OP_INTERP = 1'b1
    } op_t;

    typedef enum logic [2:0]
    {
        BK_IDLE,
        BK_READ,
        BK_BLEND_Z,
        BK_BLEND_Y,
        BK_BLEND_X,
        BK_POST,
        BK_OUT
    } bk_state_t;

    function automatic int clog2_floor(input int v);
        int r;
        int s;
        r = 0;
        s = v;
        while (s > 1)
        begin
            s = s >> 1;
            r = r + 1;
        end
        return r;
    endfunction

endpackage

### rtl/core/pgtr_front.sv
// Front end: accepts transactions, scales positions to cells, clamps and
// wraps neighbours, and forms queue entries. Depends on pgtr_pkg.
module pgtr_front
    import pgtr_pkg::*;
#(
    parameter int GRID_SIDE  = DEF_GRID_SIDE,
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    parameter int POS_BITS   = DEF_POS_BITS,
    parameter int CB         = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [SCALE_BITS-1:0] scale,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  op,
    input  logic [IDX_BITS-1:0]   idx,
    input  logic [CVAL_BITS-1:0]  cval,
    input  logic [POS_BITS-1:0]   px,
    input  logic [POS_BITS-1:0]   py,
    input  logic [POS_BITS-1:0]   pz,
    input  logic [1:0]            ax,
    input  logic                  so,
    input  logic                  fp,
    // to queue
    output logic                  q_valid,
    input  logic                  q_full,
    output logic                  q_op,
    output logic [IDX_BITS-1:0]   q_idx,
    output logic                  q_idx_ok,
    output logic [VALUE_BITS-1:0] q_val,
    output logic [3*CB-1:0]       q_lo,
    output logic [3*CB-1:0]       q_hi,
    output logic [3*FRAC_BITS-1:0] q_fr,
    output logic                  q_oob,
    output logic [1:0]            q_ax,
    output logic                  q_so,
    output logic                  q_fp
);
    localparam int PB = POS_BITS + SCALE_BITS;
    localparam int CELLS = GRID_SIDE * GRID_SIDE * GRID_SIDE;

    // stage 1: register products
    logic             s1_valid_reg;
    logic             s1_op_reg, s1_so_reg, s1_fp_reg, s1_ok_reg;
    logic [1:0]       s1_ax_reg;
    logic [IDX_BITS-1:0] s1_idx_reg;
    logic [VALUE_BITS-1:0] s1_val_reg;
    logic [PB-1:0]    s1_prod_reg [3];
    logic [POS_BITS-1:0] pos [3];
    logic             adv;

    assign pos[0] = px;
    assign pos[1] = py;
    assign pos[2] = pz;
    assign adv = !(s1_valid_reg && q_full);
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (adv)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_valid)
        begin
            s1_op_reg  <= op;
            s1_so_reg  <= so;
            s1_fp_reg  <= fp;
            s1_ax_reg  <= ax;
            s1_idx_reg <= idx;
            s1_ok_reg  <= ({17'd0, idx} < 32'(CELLS));
            s1_val_reg <= VALUE_BITS'($signed(cval));
            for (int q = 0; q < 3; q++)
                s1_prod_reg[q] <= PB'(pos[q]) * PB'(scale);
        end
    end

    // stage 1 combinational: clamp and wrap
    always_comb
    begin
        logic [PB-1:0] cell_num;
        q_oob = 1'b0;
        for (int q = 0; q < 3; q++)
        begin
            cell_num = s1_prod_reg[q] >> 24;
            if (cell_num >= PB'(GRID_SIDE))
            begin
                q_lo[q*CB +: CB] = CB'(GRID_SIDE - 1);
                q_fr[q*FRAC_BITS +: FRAC_BITS] = FRAC_ONE;
                q_oob = 1'b1;
            end
            else
            begin
                q_lo[q*CB +: CB] = cell_num[CB-1:0];
                q_fr[q*FRAC_BITS +: FRAC_BITS] = {1'b0, s1_prod_reg[q][23:8]};
            end
            if ({1'b0, q_lo[q*CB +: CB]} == (CB+1)'(GRID_SIDE - 1))
                q_hi[q*CB +: CB] = '0;
            else
                q_hi[q*CB +: CB] = q_lo[q*CB +: CB] + CB'(1);
        end
    end

    assign q_valid  = s1_valid_reg;
    assign q_op     = s1_op_reg;
    assign q_idx    = s1_idx_reg;
    assign q_idx_ok = s1_ok_reg;
    assign q_val    = s1_val_reg;
    assign q_ax     = s1_ax_reg;
    assign q_so     = s1_so_reg;
    assign q_fp     = s1_fp_reg;
endmodule

### rtl/core/pgtr_back.sv
// Back end: pops queue entries, writes the mesh memory or reads eight
// corners and blends them. Depends on pgtr_pkg.
module pgtr_back
    import pgtr_pkg::*;
#(
    parameter int GRID_SIDE  = DEF_GRID_SIDE,
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    parameter int CB         = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  e_valid,
    output logic                  e_pop,
    input  logic                  e_op,
    input  logic [IDX_BITS-1:0]   e_idx,
    input  logic                  e_idx_ok,
    input  logic [VALUE_BITS-1:0] e_val,
    input  logic [3*CB-1:0]       e_lo,
    input  logic [3*CB-1:0]       e_hi,
    input  logic [3*FRAC_BITS-1:0] e_fr,
    input  logic                  e_oob,
    input  logic [1:0]            e_ax,
    input  logic                  e_so,
    input  logic                  e_fp,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [OUT_BITS-1:0]   displacement,
    output logic [MAX_BITS-1:0]   max_displacement,
    output logic [1:0]            axis_out,
    output logic                  order_out,
    output logic                  out_of_box
);
    localparam int CELLS = GRID_SIDE * GRID_SIDE * GRID_SIDE;
    localparam int AB = $clog2(CELLS);
    localparam int SH = 3 * clog2_floor(GRID_SIDE);
    localparam int WB = VALUE_BITS + FRAC_BITS + 3;

    logic signed [VALUE_BITS-1:0] mem [CELLS];
    logic signed [VALUE_BITS-1:0] rd_reg;

    bk_state_t state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;
    logic [3*CB-1:0] lo_reg, hi_reg;
    logic [3*FRAC_BITS-1:0] fr_reg;
    logic oob_reg, so_reg, fp_reg;
    logic [1:0] ax_reg;
    logic signed [VALUE_BITS-1:0] c_reg [8];
    logic signed [VALUE_BITS-1:0] bl_next [4];
    logic signed [VALUE_BITS-1:0] d_reg;
    logic [MAX_BITS-1:0] max_reg;
    logic [AB-1:0] raddr;
    logic [1:0] sel;
    logic [FRAC_BITS-1:0] w1;
    logic mem_we;

    function automatic logic signed [VALUE_BITS-1:0] blend(
        input logic signed [VALUE_BITS-1:0] a,
        input logic signed [VALUE_BITS-1:0] b,
        input logic [FRAC_BITS-1:0] w);
        logic signed [WB-1:0] s;
        s = WB'(a) * $signed({1'b0, FRAC_ONE - w})
          + WB'(b) * $signed({1'b0, w}) + WB'(32768);
        return VALUE_BITS'(s >>> 16);
    endfunction

    // corner address: cnt bit2 = x, bit1 = y, bit0 = z
    always_comb
    begin
        logic [CB-1:0] cx, cy, cz;
        cx = cnt_reg[2] ? hi_reg[0 +: CB]  : lo_reg[0 +: CB];
        cy = cnt_reg[1] ? hi_reg[CB +: CB] : lo_reg[CB +: CB];
        cz = cnt_reg[0] ? hi_reg[2*CB +: CB] : lo_reg[2*CB +: CB];
        raddr = AB'((int'(cx) * GRID_SIDE + int'(cy)) * GRID_SIDE + int'(cz));
    end

    assign mem_we = (state_reg == BK_IDLE) && e_valid && (e_op == OP_WRITE) && e_idx_ok;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[AB'(e_idx)] <= e_val;
        rd_reg <= mem[raddr];
    end

    // blend stage selection: z, y, x
    always_comb
    begin
        sel = 2'd2;
        if (state_reg == BK_BLEND_Y)
            sel = 2'd1;
        else if (state_reg == BK_BLEND_X)
            sel = 2'd0;
        w1 = e_fr[0 +: FRAC_BITS];
        unique case (sel)
            2'd0:    w1 = fr_reg[0 +: FRAC_BITS];
            2'd1:    w1 = fr_reg[FRAC_BITS +: FRAC_BITS];
            default: w1 = fr_reg[2*FRAC_BITS +: FRAC_BITS];
        endcase
        for (int k = 0; k < 4; k++)
            bl_next[k] = blend(c_reg[2*k], c_reg[2*k+1], w1);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        unique case (state_reg)
            BK_IDLE:
                if (e_valid && e_op == OP_INTERP)
                begin
                    state_next = BK_READ;
                    cnt_next = '0;
                end
            BK_READ:
            begin
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd8)
                    state_next = BK_BLEND_Z;
            end
            BK_BLEND_Z: state_next = BK_BLEND_Y;
            BK_BLEND_Y: state_next = BK_BLEND_X;
            BK_BLEND_X: state_next = BK_POST;
            BK_POST:    state_next = BK_OUT;
            BK_OUT:
                if (!out_stall)
                    state_next = BK_IDLE;
            default:    state_next = BK_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        e_pop = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            BK_IDLE: e_pop = e_valid;
            BK_OUT:  out_valid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            cnt_reg <= '0;
            max_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            // track the saturated result
            if (state_reg == BK_POST)
            begin
                if (!displacement[OUT_BITS-1] &&
                    (fp_reg || $signed(displacement) > $signed({1'b0, max_reg})))
                    max_reg <= displacement[MAX_BITS-1:0];
                else if (fp_reg)
                    max_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        logic signed [VALUE_BITS-1:0] t;
        if (state_reg == BK_IDLE)
        begin
            lo_reg <= e_lo;
            hi_reg <= e_hi;
            fr_reg <= e_fr;
            oob_reg <= e_oob;
            so_reg <= e_so;
            fp_reg <= e_fp;
            ax_reg <= e_ax;
        end
        // read data is registered, so it arrives in the cycle after its address
        if (state_reg == BK_READ && cnt_reg != 4'd0)
            c_reg[3'(cnt_reg - 4'd1)] <= rd_reg;
        if (state_reg == BK_BLEND_Z || state_reg == BK_BLEND_Y || state_reg == BK_BLEND_X)
            for (int k = 0; k < 4; k++)
                c_reg[k] <= bl_next[k];
        if (state_reg == BK_BLEND_X)
        begin
            t = bl_next[0];
            d_reg <= so_reg ? (t >>> SH) : t;
        end
    end

    // saturate to the 24 bit result
    always_comb
    begin
        if (VALUE_BITS > OUT_BITS && d_reg > $signed(VALUE_BITS'(8388607)))
            displacement = 24'h7FFFFF;
        else if (VALUE_BITS > OUT_BITS && d_reg < -$signed(VALUE_BITS'(8388608)))
            displacement = 24'h800000;
        else
            displacement = OUT_BITS'(d_reg);
    end

    assign max_displacement = max_reg;
    assign axis_out = ax_reg;
    assign order_out = so_reg;
    assign out_of_box = oob_reg;
endmodule

### rtl/core/periodic_grid_trilinear_readout.sv
// Top level of the periodic grid trilinear readout block.
// Instantiates pgtr_front and pgtr_back with a one-entry queue between them.
//
// Channel | direction | handshake
// in      | input     | in_valid / in_stall, fields operation..first_of_pass
// out     | output    | out_valid / out_stall, fields displacement..out_of_box
// cfg     | input     | cfg_we / cfg_data (grid_scale)
//
// A mesh write is done in the pop cycle and leaves the back end idle. An
// interpolation occupies it for the pop cycle, the eight corner reads
// through the single memory port (read data is registered), three
// blend steps, one post step and the output cycle.
// With nothing queued ahead, an accepted input transaction passes the
// front register, the queue slot and the back end before its result is offered.
// Reset clears control and the running maximum; the mesh is not cleared.
// The front keeps accepting while the back works, until its register and
// the queue slot are both full; a stalled result holds the back end.
module periodic_grid_trilinear_readout
    import pgtr_pkg::*;
#(
    parameter int GRID_SIDE  = DEF_GRID_SIDE,
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    parameter int POS_BITS   = DEF_POS_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [SCALE_BITS-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  operation,
    input  logic [IDX_BITS-1:0]   cell_index,
    input  logic [CVAL_BITS-1:0]  cell_value,
    input  logic [POS_BITS-1:0]   pos_x,
    input  logic [POS_BITS-1:0]   pos_y,
    input  logic [POS_BITS-1:0]   pos_z,
    input  logic [1:0]            axis,
    input  logic                  second_order,
    input  logic                  first_of_pass,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [OUT_BITS-1:0]   displacement,
    output logic [MAX_BITS-1:0]   max_displacement,
    output logic [1:0]            axis_out,
    output logic                  order_out,
    output logic                  out_of_box
);
    localparam int CB = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;

    logic [SCALE_BITS-1:0] scale_reg;
    logic f_valid, f_op, f_ok, f_oob, f_so, f_fp;
    logic [IDX_BITS-1:0] f_idx;
    logic [VALUE_BITS-1:0] f_val;
    logic [3*CB-1:0] f_lo, f_hi;
    logic [3*FRAC_BITS-1:0] f_fr;
    logic [1:0] f_ax;

    // one-entry queue
    logic q_full_reg;
    logic e_op_reg, e_ok_reg, e_oob_reg, e_so_reg, e_fp_reg;
    logic [IDX_BITS-1:0] e_idx_reg;
    logic [VALUE_BITS-1:0] e_val_reg;
    logic [3*CB-1:0] e_lo_reg, e_hi_reg;
    logic [3*FRAC_BITS-1:0] e_fr_reg;
    logic [1:0] e_ax_reg;
    logic e_pop;
    logic q_push;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scale_reg <= SCALE_RESET;
        else if (cfg_we)
            scale_reg <= cfg_data;
    end

    pgtr_front #(
        .GRID_SIDE(GRID_SIDE), .VALUE_BITS(VALUE_BITS), .POS_BITS(POS_BITS), .CB(CB)
    ) u_front (
        .clk(clk), .rst_n(rst_n), .scale(scale_reg),
        .in_valid(in_valid), .in_stall(in_stall),
        .op(operation), .idx(cell_index), .cval(cell_value),
        .px(pos_x), .py(pos_y), .pz(pos_z),
        .ax(axis), .so(second_order), .fp(first_of_pass),
        .q_valid(f_valid), .q_full(q_full_reg && !e_pop),
        .q_op(f_op), .q_idx(f_idx), .q_idx_ok(f_ok), .q_val(f_val),
        .q_lo(f_lo), .q_hi(f_hi), .q_fr(f_fr), .q_oob(f_oob),
        .q_ax(f_ax), .q_so(f_so), .q_fp(f_fp)
    );

    // push whenever the front holds an entry and the slot frees or is empty
    assign q_push = f_valid && (!q_full_reg || e_pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q_full_reg <= 1'b0;
        else if (q_push)
            q_full_reg <= 1'b1;
        else if (e_pop)
            q_full_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (q_push)
        begin
            e_op_reg  <= f_op;
            e_idx_reg <= f_idx;
            e_ok_reg  <= f_ok;
            e_val_reg <= f_val;
            e_lo_reg  <= f_lo;
            e_hi_reg  <= f_hi;
            e_fr_reg  <= f_fr;
            e_oob_reg <= f_oob;
            e_ax_reg  <= f_ax;
            e_so_reg  <= f_so;
            e_fp_reg  <= f_fp;
        end
    end

    pgtr_back #(
        .GRID_SIDE(GRID_SIDE), .VALUE_BITS(VALUE_BITS), .CB(CB)
    ) u_back (
        .clk(clk), .rst_n(rst_n),
        .e_valid(q_full_reg), .e_pop(e_pop),
        .e_op(e_op_reg), .e_idx(e_idx_reg), .e_idx_ok(e_ok_reg), .e_val(e_val_reg),
        .e_lo(e_lo_reg), .e_hi(e_hi_reg), .e_fr(e_fr_reg), .e_oob(e_oob_reg),
        .e_ax(e_ax_reg), .e_so(e_so_reg), .e_fp(e_fp_reg),
        .out_valid(out_valid), .out_stall(out_stall),
        .displacement(displacement), .max_displacement(max_displacement),
        .axis_out(axis_out), .order_out(order_out), .out_of_box(out_of_box)
    );

    // a popped entry must have been present
    a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        e_pop |-> q_full_reg) else $error("pop from empty queue");

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(displacement))
        else $error("result changed under stall");

    // the running maximum covers every non-negative result
    a_max_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !displacement[OUT_BITS-1] |->
            max_displacement >= MAX_BITS'(displacement))
        else $error("maximum below current result");
endmodule

### dv/pgtr_checker.sv
// Checker for the periodic grid trilinear readout block.
// Watches the input, output and register channels, predicts each readout
// and compares it field by field. Depends on pgtr_pkg.
module pgtr_checker
    import pgtr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [SCALE_BITS-1:0] cfg_data,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic                  operation,
    input  logic [IDX_BITS-1:0]   cell_index,
    input  logic [CVAL_BITS-1:0]  cell_value,
    input  logic [23:0]           pos_x,
    input  logic [23:0]           pos_y,
    input  logic [23:0]           pos_z,
    input  logic [1:0]            axis,
    input  logic                  second_order,
    input  logic                  first_of_pass,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic [OUT_BITS-1:0]   displacement,
    input  logic [MAX_BITS-1:0]   max_displacement,
    input  logic [1:0]            axis_out,
    input  logic                  order_out,
    input  logic                  out_of_box,
    output int                    fail_count,
    output int                    pending,
    output int                    readouts_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SIDE = 32;

    typedef struct packed
    {
        logic [23:0] disp;
        logic [22:0] peak;
        logic [1:0]  ax;
        logic        ord;
        logic        clamp;
    } readout_t;

    readout_t        readout_q[$];
    logic [23:0]     mesh_model [0:SIDE*SIDE*SIDE-1];
    logic [23:0]     scale_model;
    longint          peak_model;

    function automatic longint round_blend(longint a, longint b, longint w1);
        return (a * (65536 - w1) + b * w1 + 32768) >>> 16;
    endfunction

    function automatic longint mesh_val(int x, int y, int z);
        return longint'(signed'(mesh_model[(x * SIDE + y) * SIDE + z]));
    endfunction

    task automatic scale_axis(input logic [23:0] p, output int lo, output int hi,
                              output longint fr, output bit clamp);
        logic [47:0] prod;
        prod = 48'(p) * 48'(scale_model);
        fr = longint'(prod[23:8]);
        lo = int'(prod[47:24]);
        clamp = 0;
        if (prod[47:24] >= SIDE)
        begin
            lo = SIDE - 1;
            fr = 65536;
            clamp = 1;
        end
        hi = (lo + 1 >= SIDE) ? 0 : lo + 1;
    endtask

    task automatic predict_readout();
        int lo[3], hi[3];
        longint fr[3], c[2][2], r[2], d;
        bit cl[3];
        readout_t e;
        scale_axis(pos_x, lo[0], hi[0], fr[0], cl[0]);
        scale_axis(pos_y, lo[1], hi[1], fr[1], cl[1]);
        scale_axis(pos_z, lo[2], hi[2], fr[2], cl[2]);
        for (int a = 0; a < 2; a++)
        begin
            for (int b = 0; b < 2; b++)
                c[a][b] = round_blend(mesh_val(a ? hi[0] : lo[0], b ? hi[1] : lo[1], lo[2]),
                                      mesh_val(a ? hi[0] : lo[0], b ? hi[1] : lo[1], hi[2]),
                                      fr[2]);
            r[a] = round_blend(c[a][0], c[a][1], fr[1]);
        end
        d = round_blend(r[0], r[1], fr[0]);
        if (second_order)
            d = d >>> 15;
        if (d > 8388607) d = 8388607;
        if (d < -8388608) d = -8388608;
        if (first_of_pass)
            peak_model = 0;
        if (d > peak_model)
            peak_model = d;
        e.disp  = d[23:0];
        e.peak  = peak_model[22:0];
        e.ax    = axis;
        e.ord   = second_order;
        e.clamp = cl[0] | cl[1] | cl[2];
        readout_q.push_back(e);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_count    <= 0;
            readouts_seen <= 0;
            pending       <= 0;
            scale_model   = SCALE_RESET;
            peak_model    = 0;
            readout_q.delete();
        end
        else
        begin
            if (cfg_we)
                scale_model = cfg_data;
            if (in_valid && !in_stall)
            begin
                if (op_t'(operation) == OP_WRITE)
                begin
                    if (cell_index < SIDE * SIDE * SIDE)
                        mesh_model[cell_index] = cell_value;
                end
                else
                    predict_readout();
            end
            if (out_valid && !out_stall)
            begin
                readouts_seen <= readouts_seen + 1;
                if (readout_q.size() == 0)
                begin
                    $display("%0t: unexpected readout disp=%h", $time, displacement);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    readout_t e;
                    readout_t got;
                    e = readout_q.pop_front();
                    got = {displacement, max_displacement, axis_out, order_out, out_of_box};
                    if (got !== e)
                    begin
                        $display("%0t: mismatch expected disp=%h max=%h ax=%0d ord=%0b oob=%0b",
                                 $time, e.disp, e.peak, e.ax, e.ord, e.clamp);
                        $display("%0t:          actual   disp=%h max=%h ax=%0d ord=%0b oob=%0b",
                                 $time, got.disp, got.peak, got.ax, got.ord, got.clamp);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= readout_q.size();
        end
    end

endmodule

### dv/periodic_grid_trilinear_readout_tb.sv
// Testbench top for the periodic grid trilinear readout block.
// Drives mesh loads, particle readouts and grid_scale settings; relies on
// pgtr_checker for prediction and on pgtr_pkg for types.
module periodic_grid_trilinear_readout_tb;
    import pgtr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SIDE  = 32;
    localparam int CELLS = SIDE * SIDE * SIDE;
    localparam int STALL_LIMIT = 20000;
    // readouts stay in cells 0..LOW_CELLS-1 or clamp; the loaded set per
    // axis is 0..LOW_CELLS plus the top cell
    localparam int LOW_CELLS = 7;
    localparam int LOAD_N    = LOW_CELLS + 2;
    localparam int PHASE_ITEMS = 160;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [SCALE_BITS-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic                  operation;
    logic [IDX_BITS-1:0]   cell_index;
    logic [CVAL_BITS-1:0]  cell_value;
    logic [23:0]           pos_x, pos_y, pos_z;
    logic [1:0]            axis;
    logic                  second_order;
    logic                  first_of_pass;
    logic                  out_valid;
    logic                  out_stall;
    logic [OUT_BITS-1:0]   displacement;
    logic [MAX_BITS-1:0]   max_displacement;
    logic [1:0]            axis_out;
    logic                  order_out;
    logic                  out_of_box;

    int  fail_count, pending, readouts_seen;
    int  idle_cycles;
    int  items_sent;
    bit  calm;          // no idling on either side while set
    bit  hold_off;      // receiver holds off for a long stretch
    bit  done;

    periodic_grid_trilinear_readout uut
    (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .operation(operation),
        .cell_index(cell_index), .cell_value(cell_value),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .axis(axis),
        .second_order(second_order), .first_of_pass(first_of_pass),
        .out_valid(out_valid), .out_stall(out_stall),
        .displacement(displacement), .max_displacement(max_displacement),
        .axis_out(axis_out), .order_out(order_out), .out_of_box(out_of_box)
    );

    pgtr_checker chk
    (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .operation(operation),
        .cell_index(cell_index), .cell_value(cell_value),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .axis(axis),
        .second_order(second_order), .first_of_pass(first_of_pass),
        .out_valid(out_valid), .out_stall(out_stall),
        .displacement(displacement), .max_displacement(max_displacement),
        .axis_out(axis_out), .order_out(order_out), .out_of_box(out_of_box),
        .fail_count(fail_count), .pending(pending), .readouts_seen(readouts_seen)
    );

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // Receiver: stall at random about 17 percent of the time, never while
    // calm, all the time during a hold-off.
    initial
    begin
        out_stall = 0;
        forever
        begin
            @(posedge clk);
            out_stall <= hold_off || (!calm && $urandom_range(99) < 17);
        end
    end

    // Watchdog: count cycles in which no transaction moves on either channel, outside a hold-off.
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || hold_off)
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Timeout after %0d cycles without a transaction", STALL_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Present one transaction and hold it until accepted. Valid stays up
    // after acceptance; the next call drops it when it idles, and
    // stop_input drops it at the end of a sequence.
    task automatic send(input op_t op, input int idx, input logic [23:0] val,
                        input logic [23:0] px, input logic [23:0] py, input logic [23:0] pz,
                        input logic [1:0] ax, input bit ord, input bit first);
        while (!calm && $urandom_range(99) < 17)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid      <= 1;
        operation     <= op;
        cell_index    <= IDX_BITS'(idx);
        cell_value    <= val;
        pos_x         <= px;
        pos_y         <= py;
        pos_z         <= pz;
        axis          <= ax;
        second_order  <= ord;
        first_of_pass <= first;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic stop_input();
        in_valid <= 0;
    endtask

    task automatic write_cell(input int idx, input logic [23:0] val);
        send(OP_WRITE, idx, val, $urandom, $urandom, $urandom, $urandom_range(2),
             $urandom_range(1), $urandom_range(1));
    endtask

    // Loaded coordinates per axis: 0..LOW_CELLS, then the top cell.
    function automatic int load_coord(input int i);
        return (i <= LOW_CELLS) ? i : SIDE - 1;
    endfunction

    // Positions whose cell stays below LOW_CELLS; one in ten clamps at the
    // far side when the scale lets a position reach it.
    function automatic logic [23:0] pick_pos(input logic [23:0] sc);
        longint s;
        longint pmax;
        longint pmin;
        int     r;
        s = (sc == 0) ? 1 : longint'(sc);
        pmax = ((longint'(LOW_CELLS) << 24) - 1) / s;
        pmin = ((longint'(SIDE) << 24) + s - 1) / s;
        if (pmax > 24'hFFFFFF)
            pmax = 24'hFFFFFF;
        r = $urandom_range(9);
        if (r == 0 && pmin <= 24'hFFFFFF)
            return 24'($urandom_range(32'hFFFFFF, 32'(pmin)));
        if (r == 1)
            return 24'(pmax);
        return 24'($urandom_range(32'(pmax)));
    endfunction

    task automatic read_particle(input logic [23:0] sc);
        send(OP_INTERP, $urandom, 24'($urandom), pick_pos(sc), pick_pos(sc), pick_pos(sc),
             $urandom_range(2), $urandom_range(1), $urandom_range(3) == 0);
    endtask

    // Wait for the block to drain, then wait out any write in flight.
    task automatic drain();
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_scale(input logic [23:0] sc);
        cfg_we   <= 1;
        cfg_data <= sc;
        @(posedge clk);
        cfg_we   <= 0;
    endtask

    initial
    begin
        logic [23:0] sc;
        logic [23:0] scales [6];
        rst_n = 0;
        cfg_we = 0;
        cfg_data = 0;
        in_valid = 0;
        operation = 0;
        cell_index = 0;
        cell_value = 0;
        pos_x = 0;
        pos_y = 0;
        pos_z = 0;
        axis = 0;
        second_order = 0;
        first_of_pass = 0;
        calm = 0;
        hold_off = 0;
        done = 0;
        items_sent = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Load every cell a readout can touch, so none reads an unwritten
        // cell. Cell zero and the last cell get the extreme values; the rest is random.
        calm = 1;
        for (int ix = 0; ix < LOAD_N; ix++)
            for (int iy = 0; iy < LOAD_N; iy++)
                for (int iz = 0; iz < LOAD_N; iz++)
                begin
                    int idx;
                    idx = (load_coord(ix) * SIDE + load_coord(iy)) * SIDE + load_coord(iz);
                    if (idx == 0)
                        write_cell(idx, 24'h7FFFFF);
                    else if (idx == CELLS - 1)
                        write_cell(idx, 24'h800000);
                    else
                        write_cell(idx, 24'($urandom));
                end
        calm = 0;

        // Directed: reset scale, origin, top edge, far clamp, order and pass flags.
        sc = SCALE_RESET;
        send(OP_INTERP, 0, 0, 0, 0, 0, 0, 0, 1);
        send(OP_INTERP, 0, 0, 24'h001F80, 24'h001FFF, 24'h0000FF, 1, 0, 0);
        send(OP_INTERP, 0, 0, 24'h002000, 24'h002000, 24'h002000, 2, 1, 0);
        send(OP_INTERP, 0, 0, 24'hFFFFFF, 0, 24'h001F00, 2, 0, 0);
        send(OP_INTERP, 0, 0, 24'h000080, 24'h000040, 24'h0000C0, 0, 1, 1);
        send(OP_INTERP, 0, 0, 0, 24'hFFFFFF, 0, 1, 0, 1);
        // Writes at the end of the mesh; an index one past it wraps to cell
        // zero in the 15 bit field.
        write_cell(CELLS - 1, 24'h800000);
        write_cell(CELLS, 24'h7FFFFF);
        write_cell(32767, 24'h123456);
        send(OP_INTERP, 0, 0, 24'h001FC0, 24'h001FC0, 24'h001FC0, 0, 0, 0);
        send(OP_INTERP, 0, 0, 24'h001FC0, 24'h001FC0, 24'h001FC0, 1, 1, 0);
        stop_input();
        drain();

        // Long hold-off at the receiver while the sender keeps offering.
        fork
            begin
                hold_off = 1;
                repeat (400) @(posedge clk);
                hold_off = 0;
            end
            begin
                for (int k = 0; k < 12; k++)
                    read_particle(sc);
                stop_input();
            end
        join
        drain();

        // Random phases across several scales, the extremes among them.
        scales[0] = 24'd1;
        scales[1] = 24'hFFFFFF;
        scales[2] = 24'd65536;
        scales[3] = 24'd8 << 16;
        scales[4] = 24'd1 << 13;
        scales[5] = 24'd0;
        for (int ph = 0; ph < 6; ph++)
        begin
            sc = (ph == 5) ? 24'd1 + 24'($urandom_range(24'hFFFFFE)) : scales[ph];
            set_scale(sc);
            calm = (ph == 2);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if ($urandom_range(9) < 2)
                    write_cell($urandom_range(CELLS - 1), 24'($urandom));
                else
                    read_particle(sc);
            end
            stop_input();
            calm = 0;
            drain();
        end

        done = 1;
        repeat (40) @(posedge clk);
        $display("Sent %0d transactions (partial mesh load plus %0d random phases);",
                 items_sent, 6);
        $display("checked %0d readouts over extreme and random grid scales.", readouts_seen);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
